// ===== sv/pjwh_pkg.sv =====
`default_nettype none

package pjwh_pkg;

  // Field widths.
  localparam int HashW  = 32;
  localparam int ByteW  = 8;
  localparam int PrimeW = 16;

  // Reset value of the bucket divisor.
  localparam logic [PrimeW-1:0] PrimeReset = 16'd251;

  // Constants of the hashpjw rule.
  localparam logic [HashW-1:0] TopMask   = 32'hf000_0000;
  localparam int               StepShift = 4;
  localparam int               FoldShift = 24;

  // Hash queue between the front and the back.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Step counter of the bit-serial remainder unit.
  localparam int StepCntW = $clog2(HashW);

  // A finished key hash on its way into the queue.
  typedef struct packed {
    logic             valid;
    logic [HashW-1:0] hash;
  } hash_push_t;

  // Fill status of the queue.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // One hashpjw step: shift in the byte, fold the top nibble into bits 7..4 and
  // clear it. When the top nibble is zero both XORs leave the value unchanged.
  function automatic logic [HashW-1:0] pjw_update(input logic [HashW-1:0] h,
                                                  input logic [ByteW-1:0] b);
    logic [HashW-1:0] sum;
    logic [HashW-1:0] top;
    sum = (h << StepShift) + {{(HashW-ByteW){1'b0}}, b};
    top = sum & TopMask;
    return sum ^ (top >> FoldShift) ^ top;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pjwh_front.sv =====
`default_nettype none

module pjwh_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [pjwh_pkg::ByteW-1:0]  key_byte_i,
  input  wire logic                        key_last_i,
  input  wire pjwh_pkg::queue_status_t     q_status_i,
  output pjwh_pkg::hash_push_t             push_o
);
  import pjwh_pkg::*;

  logic [HashW-1:0] hash_q, hash_d;
  logic [HashW-1:0] hash_next;
  logic             accept;

  // A word is taken whenever the queue has room for a possible key end.
  assign in_ready_o = ~q_status_i.full;
  assign accept     = in_valid_i & in_ready_o;
  assign hash_next  = pjw_update(hash_q, key_byte_i);

  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      hash_d = key_last_i ? '0 : hash_next;
    end
  end

  assign push_o.valid = accept & key_last_i;
  assign push_o.hash  = hash_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pjwh_queue.sv =====
`default_nettype none

module pjwh_queue (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pjwh_pkg::hash_push_t        push_i,
  input  wire logic                        pop_i,
  output logic [pjwh_pkg::HashW-1:0]       head_o,
  output pjwh_pkg::queue_status_t          status_o
);
  import pjwh_pkg::*;

  logic [HashW-1:0]     mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign status_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  assign do_push = push_i.valid & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pjwh_mod_back.sv =====
`default_nettype none

module pjwh_mod_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pjwh_pkg::queue_status_t      q_status_i,
  input  wire logic [pjwh_pkg::HashW-1:0]   q_head_i,
  output logic                              pop_o,
  input  wire logic [pjwh_pkg::PrimeW-1:0]  prime_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [pjwh_pkg::PrimeW-1:0]       bucket_index_o,
  output logic [pjwh_pkg::HashW-1:0]        full_hash_o
);
  import pjwh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_e;

  state_e              state_q;
  logic [HashW-1:0]    hash_q;
  logic [PrimeW-1:0]   div_q;
  logic [PrimeW-1:0]   rem_q;
  logic [StepCntW-1:0] cnt_q;
  logic                out_valid_q;
  logic [PrimeW-1:0]   bucket_q;
  logic [HashW-1:0]    full_q;

  logic [PrimeW:0]     rem_shift;
  logic [PrimeW:0]     rem_diff;
  logic [PrimeW-1:0]   rem_d;
  logic                out_free;

  // One restoring step per cycle, dividend bits taken from the top down.
  // The remainder stays below the divisor, so the difference fits PrimeW bits.
  assign rem_shift = {rem_q, hash_q[cnt_q]};
  assign rem_diff  = rem_shift - {1'b0, div_q};
  assign rem_d     = (rem_shift >= {1'b0, div_q}) ? rem_diff[PrimeW-1:0]
                                                  : rem_shift[PrimeW-1:0];

  assign out_free = ~out_valid_q | out_ready_i;
  assign pop_o    = (state_q == S_IDLE) & ~q_status_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hash_q      <= '0;
      div_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      bucket_q    <= '0;
      full_q      <= '0;
    end else begin
      // In the hold state a free output register always takes the next word,
      // so the word being taken only needs clearing in the other states.
      if (out_valid_q && out_ready_i && (state_q != S_HOLD)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_status_i.empty) begin
            hash_q  <= q_head_i;
            div_q   <= prime_i;
            rem_q   <= '0;
            cnt_q   <= StepCntW'(HashW - 1);
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          rem_q <= rem_d;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            // A zero divisor gives bucket zero.
            bucket_q    <= (div_q == '0) ? '0 : rem_q;
            full_q      <= hash_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bucket_index_o = bucket_q;
  assign full_hash_o    = full_q;

endmodule

`default_nettype wire

// ===== sv/pjw_string_hash_mod_prime_unit.sv =====
// A key's last byte pushes its hash into the queue; the back pops it, reduces it and registers the result word.
// Throughput: one byte word per cycle while the hash queue has room; the serial remainder unit takes
// one key at a time, in a one-bit-per-cycle loop over the 32 hash bits. A four-entry hash queue
// lets short keys run ahead of it.
// Reset is asynchronous and active low: running hash and queue clear, the divisor returns to 251.
`default_nettype none

module pjw_string_hash_mod_prime_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Key byte words.
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [pjwh_pkg::ByteW-1:0]  key_byte_i,
  input  wire logic                        key_last_i,
  // Result words.
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [pjwh_pkg::PrimeW-1:0]      bucket_index_o,
  output logic [pjwh_pkg::HashW-1:0]       full_hash_o,
  // Divisor register.
  input  wire logic                        cfg_we_i,
  input  wire logic [pjwh_pkg::PrimeW-1:0] cfg_wdata_i
);
  import pjwh_pkg::*;

  // The divisor register. The user must write it only while the unit is idle (the block
  // does not enforce this), so the back part may sample it at the start of each reduction.
  logic [PrimeW-1:0] table_prime_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_prime_q <= PrimeReset;
    end else if (cfg_we_i) begin
      table_prime_q <= cfg_wdata_i;
    end
  end

  hash_push_t       push;
  queue_status_t    q_status;
  logic [HashW-1:0] q_head;
  logic             q_pop;

  // Front: folds one byte into the running hash each cycle while the queue has room, and
  // hands the finished hash of a key to the queue on its last byte.
  pjwh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .key_byte_i (key_byte_i),
    .key_last_i (key_last_i),
    .q_status_i (q_status),
    .push_o     (push)
  );

  // Queue of finished key hashes, so that the front keeps streaming while the
  // back is busy with an earlier key.
  pjwh_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .status_o (q_status)
  );

  // Back: reduces each hash modulo the divisor one bit per cycle and holds the
  // result in an output register until it is taken.
  pjwh_mod_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .q_head_i       (q_head),
    .pop_o          (q_pop),
    .prime_i        (table_prime_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .bucket_index_o (bucket_index_o),
    .full_hash_o    (full_hash_o)
  );

endmodule

`default_nettype wire

// ===== sv/pjwh_checker.sv =====
`default_nettype none

module pjwh_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic [pjwh_pkg::ByteW-1:0]  key_byte_i,
  input wire logic                        key_last_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [pjwh_pkg::PrimeW-1:0] bucket_index_o,
  input wire logic [pjwh_pkg::HashW-1:0]  full_hash_o,
  input wire logic                        cfg_we_i,
  input wire logic [pjwh_pkg::PrimeW-1:0] cfg_wdata_i
);
  import pjwh_pkg::*;

  // Copy of the divisor as the configuration port shows it.
  logic [PrimeW-1:0] prime_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= PrimeReset;
    end else if (cfg_we_i) begin
      prime_q <= cfg_wdata_i;
    end
  end

  // A waiting byte word stays offered with its payload unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(key_byte_i) && $stable(key_last_i))
    else $error("waiting byte word changed before it was taken");

  // A result word waits until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped before it was taken");

  // A stalled result word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(bucket_index_o) && $stable(full_hash_o))
    else $error("stalled result word changed");

  // The hashpjw rule always leaves the top nibble clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> full_hash_o[HashW-1:HashW-4] == 4'h0)
    else $error("full hash has its top nibble set");

  // The bucket index lies below a nonzero divisor, and is zero for a zero one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (prime_q == '0) ? (bucket_index_o == '0) : (bucket_index_o < prime_q))
    else $error("bucket index out of range of the divisor");

endmodule

bind pjw_string_hash_mod_prime_unit pjwh_checker u_checker (.*);

`default_nettype wire
